/* src/lobm_pkg.sv */
// ----------------------------------------------------------------------------
// Order book matcher package
// Shared widths, slot and result records, codes and sequencer states.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int ORDER_SLOTS = 64;
  localparam int SLOT_BITS   = $clog2(ORDER_SLOTS);
  localparam int ID_BITS     = 31;
  localparam int PRICE_BITS  = 16;
  localparam int QTY_BITS    = 24;
  localparam int ARR_BITS    = 32;
  localparam int TOT_BITS    = 32;
  localparam int BEST_BITS   = PRICE_BITS + 1;
  localparam int MAX_RESULTS = 64;
  localparam int RES_BITS    = $clog2(MAX_RESULTS);
  localparam int CNT_BITS    = RES_BITS + 1;

  typedef enum logic [1:0] {
    CMD_LIMIT  = 2'd0,
    CMD_MARKET = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_AMEND  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_FILL      = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_RESTED    = 3'd2,
    STAT_REMAINDER = 3'd3,
    STAT_CANCELLED = 3'd4,
    STAT_NOT_FOUND = 3'd5,
    STAT_NO_LIQ    = 3'd6,
    STAT_BOOK_FULL = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    SK_BEST = 2'd0,
    SK_ID   = 2'd1,
    SK_FREE = 2'd2
  } scan_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LOOP,
    S_M_CHK,
    S_MKT_CHK,
    S_AFTER,
    S_FREE_CHK,
    S_ID_CHK,
    S_FINISH,
    S_BID,
    S_ASK,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic                  buy;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic [ARR_BITS-1:0]   arrival;
  } slot_t;

  typedef struct packed {
    logic [ID_BITS-1:0]    rest_id;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic                  gone;
    logic [QTY_BITS-1:0]   rem;
    logic [TOT_BITS-1:0]   total;
  } res_t;

  typedef struct packed {
    logic               start;
    scan_kind_t         kind;
    logic               side;
    logic [ID_BITS-1:0] id;
  } scan_req_t;

  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [SLOT_BITS-1:0] idx;
    slot_t                entry;
  } scan_rsp_t;

endpackage

/* src/lobm_slot_mem.sv */
// ----------------------------------------------------------------------------
// Order slot memory
// One write port and one registered read port for the resting orders.
// ----------------------------------------------------------------------------
module lobm_slot_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lobm_pkg::SLOT_BITS-1:0] waddr,
  input  lobm_pkg::slot_t               wdata,
  input  logic [lobm_pkg::SLOT_BITS-1:0] raddr,
  output lobm_pkg::slot_t               rdata
);
  import lobm_pkg::*;

  slot_t mem [ORDER_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lobm_res_mem.sv */
// ----------------------------------------------------------------------------
// Result buffer
// Holds the fills of one request until the book summary is known.
// ----------------------------------------------------------------------------
module lobm_res_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [lobm_pkg::RES_BITS-1:0] waddr,
  input  lobm_pkg::res_t               wdata,
  input  logic [lobm_pkg::RES_BITS-1:0] raddr,
  output lobm_pkg::res_t               rdata
);
  import lobm_pkg::*;

  res_t mem [MAX_RESULTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lobm_scan.sv */
// ----------------------------------------------------------------------------
// Slot scan unit
// Walks all slots once and keeps the best order, the first id hit or the
// first free slot, using one shared compare.
// ----------------------------------------------------------------------------
module lobm_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  lobm_pkg::scan_req_t            req,
  input  logic [lobm_pkg::ORDER_SLOTS-1:0] valid_bits,
  output logic [lobm_pkg::SLOT_BITS-1:0] mem_raddr,
  input  lobm_pkg::slot_t                mem_rdata,
  output lobm_pkg::scan_rsp_t            rsp
);
  import lobm_pkg::*;

  logic                 busy;
  logic [SLOT_BITS:0]   cnt;
  logic                 pend;
  logic [SLOT_BITS-1:0] pidx;
  logic                 pvld;
  scan_kind_t           kind;
  logic                 side;
  logic [ID_BITS-1:0]   id;
  logic                 found;
  logic [SLOT_BITS-1:0] idx;
  slot_t                entry;
  logic                 issue;
  logic                 cand;
  logic                 better;
  logic [ARR_BITS-1:0]  arr_diff;
  logic                 take;

  assign issue     = busy && !cnt[SLOT_BITS];
  assign mem_raddr = cnt[SLOT_BITS-1:0];
  assign arr_diff  = mem_rdata.arrival - entry.arrival;

  always_comb begin
    case (kind)
      SK_BEST: cand = pvld && (mem_rdata.buy == side);
      SK_ID:   cand = pvld && (mem_rdata.id == id);
      SK_FREE: cand = !pvld;
      default: cand = 1'b0;
    endcase
    better = (side ? (mem_rdata.price > entry.price) : (mem_rdata.price < entry.price))
             || ((mem_rdata.price == entry.price) && arr_diff[ARR_BITS-1]);
    take = pend && cand && (!found || ((kind == SK_BEST) && better));
  end

  assign rsp.done  = busy && cnt[SLOT_BITS] && !pend;
  assign rsp.found = found;
  assign rsp.idx   = idx;
  assign rsp.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
      kind  <= req.kind;
      side  <= req.side;
      id    <= req.id;
    end else begin
      pend <= issue;
      if (issue) begin
        pidx <= cnt[SLOT_BITS-1:0];
        pvld <= valid_bits[cnt[SLOT_BITS-1:0]];
        cnt  <= cnt + 1'b1;
      end
      if (take) begin
        found <= 1'b1;
        idx   <= pidx;
        entry <= mem_rdata;
      end
      if (rsp.done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* src/limit_order_book_matcher_unit.sv */
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority matching over a fixed pool of resting orders.
// Each request costs one slot scan per fill, one more for a match attempt that
// finds nothing to cross, and up to four more (id, free slot, best bid, best
// ask), then the results go out one at a time. One request is handled at a time.
// Reset empties the book and clears the arrival counter and the matched total;
// slot contents need no clearing.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // order_id[30:0], is_buy[31], price[47:32], quantity[71:48]
  input  logic [71:0]  s_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // incoming_id[30:0], resting_id[61:31], fill_price[77:62], fill_qty[101:78],
  // resting_filled[102], remaining_qty[126:103], best_bid[143:127],
  // best_ask[160:144], total_matched[192:161], zero fill[199:193]
  output logic [199:0] m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);
  import lobm_pkg::*;

  state_t                 state;
  state_t                 state_next;
  state_t                 ret;
  cmd_t                   cmd;
  logic [ID_BITS-1:0]     in_id;
  logic                   side;
  logic [PRICE_BITS-1:0]  limit;
  logic [QTY_BITS-1:0]    rem;
  logic [CNT_BITS-1:0]    n;
  logic [CNT_BITS-1:0]    out_k;
  status_t                fin;
  logic [TOT_BITS-1:0]    total;
  logic [ARR_BITS-1:0]    arrival;
  logic [ORDER_SLOTS-1:0] valid;
  logic [BEST_BITS-1:0]   bid;
  logic [BEST_BITS-1:0]   ask;
  logic [199:0]           out_data;
  logic [2:0]             out_user;
  logic                   out_last;
  logic                   out_valid;

  logic                   accept;
  cmd_t                   in_cmd;
  scan_req_t              scan_req;
  scan_rsp_t              scan_rsp;
  logic [SLOT_BITS-1:0]   slot_raddr;
  slot_t                  slot_rdata;
  logic                   slot_we;
  logic [SLOT_BITS-1:0]   slot_waddr;
  slot_t                  slot_wdata;
  logic                   res_we;
  logic [RES_BITS-1:0]    res_waddr;
  res_t                   res_wdata;
  res_t                   res_rdata;
  logic                   market;
  logic                   crossed;
  logic                   proceed;
  logic [QTY_BITS-1:0]    fq;
  logic [QTY_BITS-1:0]    newq;
  logic                   is_final;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_cmd   = cmd_t'(s_tuser);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

  assign market   = (cmd == CMD_MARKET);
  assign crossed  = side ? !(limit < scan_rsp.entry.price) : !(limit > scan_rsp.entry.price);
  assign proceed  = scan_rsp.found && (market || crossed);
  assign fq       = (scan_rsp.entry.qty < rem) ? scan_rsp.entry.qty : rem;
  assign newq     = scan_rsp.entry.qty - fq;
  assign is_final = ((out_k + 1'b1) == n);

  lobm_slot_mem u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  lobm_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .req        (scan_req),
    .valid_bits (valid),
    .mem_raddr  (slot_raddr),
    .mem_rdata  (slot_rdata),
    .rsp        (scan_rsp)
  );

  lobm_res_mem u_res (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (out_k[RES_BITS-1:0]),
    .rdata (res_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_cmd == CMD_LIMIT) ? S_LOOP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          state_next = ret;
        end
      end
      S_LOOP: begin
        if ((rem == '0) || (n == CNT_BITS'(MAX_RESULTS))) begin
          state_next = S_AFTER;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_M_CHK:    state_next = proceed ? S_LOOP : S_AFTER;
      S_MKT_CHK: begin
        if (!scan_rsp.found) begin
          state_next = S_FINISH;
        end else if (rem == '0) begin
          state_next = S_AFTER;
        end else begin
          state_next = S_M_CHK;
        end
      end
      S_AFTER:    state_next = (market || (rem == '0)) ? S_FINISH : S_SCAN;
      S_FREE_CHK: state_next = S_FINISH;
      S_ID_CHK: begin
        if (!scan_rsp.found || (cmd == CMD_CANCEL)) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_FINISH:   state_next = S_SCAN;
      S_BID:      state_next = S_SCAN;
      S_ASK:      state_next = S_OUT_RD;
      S_OUT_RD:   state_next = S_OUT_LD;
      S_OUT_LD:   state_next = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (m_tready) begin
          state_next = is_final ? S_IDLE : S_OUT_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    scan_req   = '0;
    slot_we    = 1'b0;
    slot_waddr = scan_rsp.idx;
    slot_wdata = scan_rsp.entry;
    res_we     = 1'b0;
    res_waddr  = n[RES_BITS-1:0];
    res_wdata  = '0;
    case (state)
      S_IDLE: begin
        if (accept && (in_cmd != CMD_LIMIT)) begin
          scan_req.start = 1'b1;
          scan_req.kind  = (in_cmd == CMD_MARKET) ? SK_BEST : SK_ID;
          scan_req.side  = !s_tdata[31];
          scan_req.id    = s_tdata[30:0];
        end
      end
      S_LOOP: begin
        if ((rem != '0) && (n != CNT_BITS'(MAX_RESULTS))) begin
          scan_req.start = 1'b1;
          scan_req.kind  = SK_BEST;
          scan_req.side  = !side;
        end
      end
      S_M_CHK: begin
        if (proceed) begin
          slot_we             = (newq != '0);
          slot_wdata.qty      = newq;
          res_we              = 1'b1;
          res_wdata.rest_id   = scan_rsp.entry.id;
          res_wdata.price     = scan_rsp.entry.price;
          res_wdata.qty       = fq;
          res_wdata.gone      = (newq == '0);
          res_wdata.rem       = rem - fq;
          res_wdata.total     = total + TOT_BITS'(fq);
        end
      end
      S_AFTER: begin
        if (!market && (rem != '0)) begin
          scan_req.start = 1'b1;
          scan_req.kind  = SK_FREE;
        end
      end
      S_FREE_CHK: begin
        if (scan_rsp.found) begin
          slot_we            = 1'b1;
          slot_wdata.id      = in_id;
          slot_wdata.buy     = side;
          slot_wdata.price   = limit;
          slot_wdata.qty     = rem;
          slot_wdata.arrival = arrival;
        end
      end
      S_FINISH: begin
        scan_req.start = 1'b1;
        scan_req.kind  = SK_BEST;
        scan_req.side  = 1'b1;
        if (n == '0) begin
          res_we          = 1'b1;
          res_wdata.rem   = ((fin == STAT_CANCELLED) || (fin == STAT_NOT_FOUND)) ? '0 : rem;
          res_wdata.total = total;
        end
      end
      S_BID: begin
        scan_req.start = 1'b1;
        scan_req.kind  = SK_BEST;
        scan_req.side  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      valid     <= '0;
      arrival   <= '0;
      total     <= '0;
      n         <= '0;
      out_k     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd   <= in_cmd;
            in_id <= s_tdata[30:0];
            side  <= s_tdata[31];
            limit <= s_tdata[47:32];
            rem   <= s_tdata[71:48];
            n     <= '0;
            ret   <= (in_cmd == CMD_MARKET) ? S_MKT_CHK : S_ID_CHK;
          end
        end
        S_LOOP:   ret <= S_M_CHK;
        S_M_CHK: begin
          if (proceed) begin
            rem   <= rem - fq;
            total <= total + TOT_BITS'(fq);
            n     <= n + 1'b1;
            if (newq == '0) begin
              valid[scan_rsp.idx] <= 1'b0;
            end
          end
        end
        S_MKT_CHK: begin
          if (!scan_rsp.found) begin
            fin <= STAT_NO_LIQ;
          end
        end
        S_AFTER: begin
          ret <= S_FREE_CHK;
          if (market) begin
            fin <= (rem != '0) ? STAT_REMAINDER : STAT_FULL;
          end else if (rem == '0) begin
            fin <= STAT_FULL;
          end
        end
        S_FREE_CHK: begin
          if (scan_rsp.found) begin
            valid[scan_rsp.idx] <= 1'b1;
            arrival             <= arrival + 1'b1;
            fin                 <= STAT_RESTED;
          end else begin
            fin <= STAT_BOOK_FULL;
          end
        end
        S_ID_CHK: begin
          if (!scan_rsp.found) begin
            fin <= STAT_NOT_FOUND;
          end else begin
            valid[scan_rsp.idx] <= 1'b0;
            side                <= scan_rsp.entry.buy;
            fin                 <= STAT_CANCELLED;
          end
        end
        S_FINISH: begin
          ret <= S_BID;
          if (n == '0) begin
            n <= CNT_BITS'(1);
          end
        end
        S_BID: begin
          ret <= S_ASK;
          bid <= scan_rsp.found ? {1'b0, scan_rsp.entry.price} : '1;
        end
        S_ASK: begin
          ask   <= scan_rsp.found ? {1'b0, scan_rsp.entry.price} : '1;
          out_k <= '0;
        end
        S_OUT_LD: begin
          out_valid <= 1'b1;
          out_data  <= {7'b0, res_rdata.total, ask, bid, res_rdata.rem, res_rdata.gone,
                        res_rdata.qty, res_rdata.price, res_rdata.rest_id, in_id};
          out_user  <= is_final ? fin : STAT_FILL;
          out_last  <= is_final;
        end
        S_OUT_WAIT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            out_k     <= out_k + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
